[sv/jse_pkg.sv]
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types, command and error codes, and character constants for the
// streaming JSON text emitter.
// ----------------------------------------------------------------------------
package jse_pkg;

    typedef enum logic [3:0] {
        CMD_OPEN     = 4'd0,
        CMD_ENTRY    = 4'd1,
        CMD_KEYOPEN  = 4'd2,
        CMD_KEYBYTE  = 4'd3,
        CMD_KEYCLOSE = 4'd4,
        CMD_STROPEN  = 4'd5,
        CMD_STRBYTE  = 4'd6,
        CMD_STRCLOSE = 4'd7,
        CMD_RAW      = 4'd8,
        CMD_CLOSE    = 4'd9,
        CMD_CLOSEALL = 4'd10
    } cmd_t;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_FINISHED  = 3'd1;
    localparam logic [2:0] ERR_EMPTY     = 3'd2;
    localparam logic [2:0] ERR_KIND      = 3'd3;
    localparam logic [2:0] ERR_EMPTY_KEY = 3'd4;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd5;

    localparam logic KIND_ARRAY  = 1'b0;
    localparam logic KIND_OBJECT = 1'b1;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;

    // One level of the nesting stack.
    typedef struct packed {
        logic kind;
        logic first;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{kind: KIND_ARRAY, first: 1'b1};

    // Stack command that travels down the cell chain.
    typedef struct packed {
        logic push;
        logic pop;
        logic clr_first;
        logic push_kind;
    } stack_op_t;

    // Character that follows the backslash of an escape, or zero if the byte
    // goes out unchanged.
    function automatic logic [7:0] esc_char(input logic [7:0] b);
        logic [7:0] e;
        case (b)
            CH_QUOTE:     e = CH_QUOTE;
            CH_BACKSLASH: e = CH_BACKSLASH;
            CH_SLASH:     e = CH_SLASH;
            CH_BS:        e = CH_LOWER_B;
            CH_FF:        e = CH_LOWER_F;
            CH_LF:        e = CH_LOWER_N;
            CH_CR:        e = CH_LOWER_R;
            CH_TAB:       e = CH_LOWER_T;
            default:      e = 8'h00;
        endcase
        return e;
    endfunction

endpackage

[sv/jse_cell.sv]
// ----------------------------------------------------------------------------
// jse_cell
// One level of the nesting stack: holds a collection kind and a first-entry
// flag and shifts toward either neighbor on push or pop.
// ----------------------------------------------------------------------------
module jse_cell
    import jse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  stack_op_t op,
    input  logic      clr,
    input  entry_t    from_up,
    input  entry_t    from_down,
    output entry_t    q
);

    entry_t q_reg;
    entry_t q_next;

    always_comb
    begin
        q_next = q_reg;
        if (op.push)
        begin
            q_next = from_up;
        end
        else if (op.pop)
        begin
            q_next = from_down;
        end
        else if (clr)
        begin
            q_next.first = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= ENTRY_RESET;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

[sv/jse_stack.sv]
// ----------------------------------------------------------------------------
// jse_stack
// Nesting stack built as a chain of cells. Cell 0 is the top of the stack;
// a push shifts every level one cell down, a pop shifts them one cell up.
// ----------------------------------------------------------------------------
module jse_stack
    import jse_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  stack_op_t op,
    output entry_t    top
);

    entry_t cell_q [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            entry_t up_d;
            entry_t down_d;
            logic   clr_d;

            if (i == 0)
            begin : g_top
                assign up_d  = '{kind: op.push_kind, first: 1'b1};
                assign clr_d = op.clr_first;
            end
            else
            begin : g_mid
                assign up_d  = cell_q[i-1];
                assign clr_d = 1'b0;
            end

            if (i == DEPTH - 1)
            begin : g_bottom
                assign down_d = ENTRY_RESET;
            end
            else
            begin : g_inner
                assign down_d = cell_q[i+1];
            end

            jse_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .op        (op),
                .clr       (clr_d),
                .from_up   (up_d),
                .from_down (down_d),
                .q         (cell_q[i])
            );
        end
    endgenerate

    assign top = cell_q[0];

endmodule

[sv/json_stream_emitter.sv]
// ----------------------------------------------------------------------------
// json_stream_emitter
// Streaming JSON serializer: turns serializer commands into JSON text bytes,
// inserting separators, quoting and escaping, with a nesting stack of cells.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Carries
//  ---------+-----+-----------------------------------------------------------
//  s_*      | in  | one serializer command per transaction
//  m_*      | out | one text byte or one status result per transaction
//
//  Commands that yield one result can follow each other every cycle unless
//  the output stalls; two-byte results (escapes, separators before a key,
//  key close) keep their second byte in the single pending-byte register
//  behind the output register. Close-all pops one level per cycle while the
//  output is free, emitting its closing byte. Reset clears the stack and
//  all control state at once; no clearing pass is needed. A stalled output
//  holds its result and blocks new commands until the slot frees.
// ----------------------------------------------------------------------------
module json_stream_emitter
    import jse_pkg::*;
#(
    parameter int STACK_DEPTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [4:0] s_tuser,   // [3:0] cmd, [4] coll_kind
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] text_byte
    output logic [3:0] m_tuser,   // [0] byte_valid, [3:1] error_code
    output logic       m_tlast
);

    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam logic [LW-1:0] LEVEL_FULL = LW'(STACK_DEPTH);
    localparam logic [LW-1:0] LEVEL_ONE  = LW'(1);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_CLOSE = 2'b10
    } state_t;

    state_t       state_reg, state_next;
    logic [LW-1:0] level_reg, level_next;
    logic         started_reg, started_next;
    logic         key_seen_reg, key_seen_next;

    logic         out_valid_reg, out_valid_next;
    logic [7:0]   out_byte_reg, out_byte_next;
    logic         out_bv_reg, out_bv_next;
    logic [2:0]   out_err_reg, out_err_next;
    logic         out_last_reg, out_last_next;

    logic         pend_valid_reg, pend_valid_next;
    logic [7:0]   pend_byte_reg, pend_byte_next;

    stack_op_t    op;
    entry_t       top;

    logic [3:0]   in_cmd;
    logic         in_kind;
    logic [7:0]   in_byte;
    logic         accept;
    logic         slot_free;
    logic         finished;
    logic         empty;

    // Decoded effect of the command at the input.
    logic [2:0]   d_err;
    logic [1:0]   d_nbytes;
    logic [7:0]   d_b0;
    logic [7:0]   d_b1;
    logic         d_push;
    logic         d_pop;
    logic         d_clr;
    logic         d_start;
    logic         d_key_set;
    logic         d_key_clr;
    logic         d_closeall;
    logic [7:0]   esc;

    assign in_cmd  = s_tuser[3:0];
    assign in_kind = s_tuser[4];
    assign in_byte = s_tdata;

    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && !pend_valid_reg && slot_free;
    assign accept    = s_tvalid && s_tready;

    assign finished = started_reg && (level_reg == '0);
    assign empty    = (level_reg == '0);
    assign esc      = esc_char(in_byte);

    always_comb
    begin
        d_err      = ERR_OK;
        d_nbytes   = 2'd0;
        d_b0       = 8'h00;
        d_b1       = 8'h00;
        d_push     = 1'b0;
        d_pop      = 1'b0;
        d_clr      = 1'b0;
        d_start    = 1'b0;
        d_key_set  = 1'b0;
        d_key_clr  = 1'b0;
        d_closeall = 1'b0;
        case (in_cmd)
            CMD_OPEN:
            begin
                if (finished)
                    d_err = ERR_FINISHED;
                else if (level_reg == LEVEL_FULL)
                    d_err = ERR_OVERFLOW;
                else
                begin
                    d_b0     = in_kind ? CH_LBRACE : CH_LBRACKET;
                    d_nbytes = 2'd1;
                    d_push   = 1'b1;
                    d_start  = 1'b1;
                end
            end
            CMD_ENTRY:
            begin
                if (empty)
                    d_err = ERR_EMPTY;
                else if (top.kind != KIND_ARRAY)
                    d_err = ERR_KIND;
                else if (top.first)
                    d_clr = 1'b1;
                else
                begin
                    d_b0     = CH_COMMA;
                    d_nbytes = 2'd1;
                end
            end
            CMD_KEYOPEN:
            begin
                if (empty)
                    d_err = ERR_EMPTY;
                else if (top.kind != KIND_OBJECT)
                    d_err = ERR_KIND;
                else
                begin
                    d_start   = 1'b1;
                    d_key_clr = 1'b1;
                    if (top.first)
                    begin
                        d_clr    = 1'b1;
                        d_b0     = CH_QUOTE;
                        d_nbytes = 2'd1;
                    end
                    else
                    begin
                        d_b0     = CH_COMMA;
                        d_b1     = CH_QUOTE;
                        d_nbytes = 2'd2;
                    end
                end
            end
            CMD_KEYBYTE, CMD_STRBYTE:
            begin
                if (finished)
                    d_err = ERR_FINISHED;
                else
                begin
                    d_start   = 1'b1;
                    d_key_set = (in_cmd == CMD_KEYBYTE);
                    if (esc != 8'h00)
                    begin
                        d_b0     = CH_BACKSLASH;
                        d_b1     = esc;
                        d_nbytes = 2'd2;
                    end
                    else
                    begin
                        d_b0     = in_byte;
                        d_nbytes = 2'd1;
                    end
                end
            end
            CMD_KEYCLOSE:
            begin
                if (!key_seen_reg)
                    d_err = ERR_EMPTY_KEY;
                else if (finished)
                    d_err = ERR_FINISHED;
                else
                begin
                    d_start   = 1'b1;
                    d_key_clr = 1'b1;
                    d_b0      = CH_QUOTE;
                    d_b1      = CH_COLON;
                    d_nbytes  = 2'd2;
                end
            end
            CMD_STROPEN, CMD_STRCLOSE:
            begin
                if (finished)
                    d_err = ERR_FINISHED;
                else
                begin
                    d_start  = 1'b1;
                    d_b0     = CH_QUOTE;
                    d_nbytes = 2'd1;
                end
            end
            CMD_RAW:
            begin
                if (finished)
                    d_err = ERR_FINISHED;
                else
                begin
                    d_start  = 1'b1;
                    d_b0     = in_byte;
                    d_nbytes = 2'd1;
                end
            end
            CMD_CLOSE:
            begin
                if (empty)
                    d_err = ERR_EMPTY;
                else
                begin
                    d_b0     = top.kind ? CH_RBRACE : CH_RBRACKET;
                    d_nbytes = 2'd1;
                    d_pop    = 1'b1;
                end
            end
            CMD_CLOSEALL:
            begin
                // With nothing to close this falls through to a status result.
                d_closeall = started_reg && !empty;
            end
            default:
            begin
                d_nbytes = 2'd0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        level_next      = level_reg;
        started_next    = started_reg;
        key_seen_next   = key_seen_reg;
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_bv_next     = out_bv_reg;
        out_err_next    = out_err_reg;
        out_last_next   = out_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        op              = '{push: 1'b0, pop: 1'b0, clr_first: 1'b0, push_kind: in_kind};

        if (pend_valid_reg && slot_free)
        begin
            out_valid_next  = 1'b1;
            out_byte_next   = pend_byte_reg;
            out_bv_next     = 1'b1;
            out_err_next    = ERR_OK;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
        else if ((state_reg == ST_CLOSE) && slot_free)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = top.kind ? CH_RBRACE : CH_RBRACKET;
            out_bv_next    = 1'b1;
            out_err_next   = ERR_OK;
            out_last_next  = (level_reg == LEVEL_ONE);
            op.pop         = 1'b1;
            level_next     = level_reg - LEVEL_ONE;
            if (level_reg == LEVEL_ONE)
                state_next = ST_IDLE;
        end
        else if (accept)
        begin
            op.push      = d_push;
            op.pop       = d_pop;
            op.clr_first = d_clr;
            if (d_push)
                level_next = level_reg + LEVEL_ONE;
            else if (d_pop)
                level_next = level_reg - LEVEL_ONE;
            if (d_start)
                started_next = 1'b1;
            if (d_key_set)
                key_seen_next = 1'b1;
            else if (d_key_clr)
                key_seen_next = 1'b0;

            if (d_closeall)
            begin
                state_next     = ST_CLOSE;
                out_valid_next = 1'b0;
            end
            else if (d_nbytes == 2'd0)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = 8'h00;
                out_bv_next    = 1'b0;
                out_err_next   = d_err;
                out_last_next  = 1'b1;
            end
            else
            begin
                out_valid_next  = 1'b1;
                out_byte_next   = d_b0;
                out_bv_next     = 1'b1;
                out_err_next    = ERR_OK;
                out_last_next   = (d_nbytes == 2'd1);
                pend_valid_next = (d_nbytes == 2'd2);
                pend_byte_next  = d_b1;
            end
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            level_reg      <= '0;
            started_reg    <= 1'b0;
            key_seen_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            level_reg      <= level_next;
            started_reg    <= started_next;
            key_seen_reg   <= key_seen_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg  <= out_byte_next;
        out_bv_reg    <= out_bv_next;
        out_err_reg   <= out_err_next;
        out_last_reg  <= out_last_next;
        pend_byte_reg <= pend_byte_next;
    end

    jse_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .top   (top)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_err_reg, out_bv_reg};
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    // A pending second byte always sits behind a loaded first byte.
    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("pending byte without a result in the output register");

    // No command is taken while close-all is still walking the stack.
    a_no_accept_closing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLOSE) |-> !s_tready)
        else $error("command accepted during close-all");

    // The nesting level never passes the stack depth.
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LEVEL_FULL)
        else $error("stack level beyond depth");

    // Close-all only runs while there is something to close.
    a_closing_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLOSE) |-> (level_reg != '0))
        else $error("close-all running on an empty stack");
`endif

endmodule
